// ----- sv/fpa_pkg.sv -----
// fpa_pkg: action codes, beat payload types and the saturation helper
// for the fixed-point alu; no dependencies
package fpa_pkg;

    typedef enum logic [3:0] {
        ACT_ADD     = 4'd0,
        ACT_SUB     = 4'd1,
        ACT_MUL     = 4'd2,
        ACT_DIV     = 4'd3,
        ACT_MIN     = 4'd4,
        ACT_MAX     = 4'd5,
        ACT_INC     = 4'd6,
        ACT_DEC     = 4'd7,
        ACT_TO_INT  = 4'd8,
        ACT_FROM_INT = 4'd9
    } t_action;

    localparam logic signed [31:0] W32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] W32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_greater;
        logic               a_less;
        logic               a_equal;
        logic               overflow;
        logic               divide_by_zero;
    } t_out_beat;

    // everything but the quotient, carried along the divider row
    typedef struct packed {
        t_out_beat beat;
        logic      is_div;
        logic      q_neg;
    } t_side;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat sat64(input logic signed [63:0] v);
        t_sat s;
        s.ovf = 1'b0;
        s.val = v[31:0];
        if (v > 64'(W32_MAX)) begin
            s.ovf = 1'b1;
            s.val = W32_MAX;
        end else if (v < 64'(W32_MIN)) begin
            s.ovf = 1'b1;
            s.val = W32_MIN;
        end
        return s;
    endfunction

endpackage

// ----- sv/fpa_if.sv -----
// fpa_in_if and fpa_out_if: valid/ready channels of the fixed-point alu
// depends on fpa_pkg for the payload types
interface fpa_in_if;
    logic               valid;
    logic               ready;
    fpa_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fpa_out_if;
    logic               valid;
    logic               ready;
    fpa_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/fpa_front.sv -----
// fpa_front: operand register with multiplier, then all non-divide actions,
// flags and divider setup; depends on fpa_pkg
module fpa_front #(
    parameter int FRACTION_BITS = 8,
    parameter int NW = 33 + FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  fpa_pkg::t_in_beat  i_beat,
    output logic               o_vld,
    output fpa_pkg::t_side     o_side,
    output logic [NW-1:0]      o_n,
    output logic [33:0]        o_d
);
    import fpa_pkg::*;

    logic               r_vld_a;
    logic [3:0]         r_act;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [63:0] r_prod;

    logic               r_vld_b;
    t_side              r_side;
    logic [NW-1:0]      r_n;
    logic [33:0]        r_d;

    t_side              n_side;
    logic [NW-1:0]      n_n;
    logic [33:0]        n_d;

    logic signed [63:0] a64, b64, mul_v;
    logic [63:0]        mul_m, mul_q, mag_a, mag_b;
    t_sat               s_add, s_sub, s_mul, s_inc, s_dec, s_from;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
        if (i_en) begin
            r_act  <= i_beat.action;
            r_a    <= i_beat.operand_a;
            r_b    <= i_beat.operand_b;
            r_prod <= 64'(i_beat.operand_a) * 64'(i_beat.operand_b);
            r_side <= n_side;
            r_n    <= n_n;
            r_d    <= n_d;
        end
    end

    always_comb begin
        a64    = 64'(r_a);
        b64    = 64'(r_b);
        s_add  = sat64(a64 + b64);
        s_sub  = sat64(a64 - b64);
        s_inc  = sat64(a64 + 64'sd1);
        s_dec  = sat64(a64 - 64'sd1);
        s_from = sat64(a64 <<< FRACTION_BITS);
        // magnitude of the product, rounded half away from zero
        mul_m  = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
        mul_q  = (mul_m + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        mul_v  = r_prod[63] ? -$signed(mul_q) : $signed(mul_q);
        s_mul  = sat64(mul_v);
        mag_a  = r_a[31] ? 64'(-a64) : 64'(a64);
        mag_b  = r_b[31] ? 64'(-b64) : 64'(b64);
        // quotient = (2n + d) / (2d) with n = |a| << F
        n_n    = NW'((mag_a << (FRACTION_BITS + 1)) + mag_b);
        n_d    = 34'(mag_b << 1);

        n_side = '0;
        n_side.beat.a_greater = r_a > r_b;
        n_side.beat.a_less    = r_a < r_b;
        n_side.beat.a_equal   = r_a == r_b;
        n_side.q_neg          = r_a[31] ^ r_b[31];
        case (r_act)
            ACT_ADD: begin
                n_side.beat.result   = s_add.val;
                n_side.beat.overflow = s_add.ovf;
            end
            ACT_SUB: begin
                n_side.beat.result   = s_sub.val;
                n_side.beat.overflow = s_sub.ovf;
            end
            ACT_MUL: begin
                n_side.beat.result   = s_mul.val;
                n_side.beat.overflow = s_mul.ovf;
            end
            ACT_DIV: begin
                if (r_b == 32'sd0) begin
                    n_side.beat.divide_by_zero = 1'b1;
                    n_side.beat.result = (r_a > 32'sd0) ? W32_MAX :
                                         (r_a < 32'sd0) ? W32_MIN : 32'sd0;
                end else begin
                    n_side.is_div = 1'b1;
                end
            end
            ACT_MIN: n_side.beat.result = (r_a < r_b) ? r_a : r_b;
            ACT_MAX: n_side.beat.result = (r_a > r_b) ? r_a : r_b;
            ACT_INC: begin
                n_side.beat.result   = s_inc.val;
                n_side.beat.overflow = s_inc.ovf;
            end
            ACT_DEC: begin
                n_side.beat.result   = s_dec.val;
                n_side.beat.overflow = s_dec.ovf;
            end
            ACT_TO_INT: n_side.beat.result = r_a >>> FRACTION_BITS;
            ACT_FROM_INT: begin
                n_side.beat.result   = s_from.val;
                n_side.beat.overflow = s_from.ovf;
            end
            default: n_side.beat.result = 32'sd0;
        endcase
    end

    assign o_vld  = r_vld_b;
    assign o_side = r_side;
    assign o_n    = r_n;
    assign o_d    = r_d;
endmodule

// ----- sv/fpa_div_cell.sv -----
// fpa_div_cell: one restoring-division step, one quotient bit per cell,
// carries the rest of the beat along; depends on fpa_pkg
module fpa_div_cell #(
    parameter int NW = 41
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  fpa_pkg::t_side  i_side,
    input  logic [NW-1:0]   i_n,
    input  logic [33:0]     i_r,
    input  logic [33:0]     i_d,
    input  logic [NW-1:0]   i_q,
    output logic            o_vld,
    output fpa_pkg::t_side  o_side,
    output logic [NW-1:0]   o_n,
    output logic [33:0]     o_r,
    output logic [33:0]     o_d,
    output logic [NW-1:0]   o_q
);
    import fpa_pkg::*;

    logic          r_vld;
    t_side         r_side;
    logic [NW-1:0] r_n, r_q;
    logic [33:0]   r_r, r_d;
    logic [33:0]   n_r, trial;
    logic          qbit;

    always_comb begin
        // remainder stays below the divisor, so 33 bits hold it
        trial = {i_r[32:0], i_n[NW-1]};
        qbit  = trial >= i_d;
        n_r   = qbit ? trial - i_d : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_side <= i_side;
            r_n    <= {i_n[NW-2:0], 1'b0};
            r_r    <= n_r;
            r_d    <= i_d;
            r_q    <= {i_q[NW-2:0], qbit};
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_n    = r_n;
    assign o_r    = r_r;
    assign o_d    = r_d;
    assign o_q    = r_q;
endmodule

// ----- sv/fpa_out_buf.sv -----
// fpa_out_buf: output register plus skid register; ready upstream comes
// from a flop only; depends on fpa_pkg and fpa_out_if
module fpa_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fpa_pkg::t_out_beat i_beat,
    output logic               o_room,
    fpa_out_if.source          o_out
);
    import fpa_pkg::*;

    logic      r_ov, r_sv;
    t_out_beat r_od, r_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || o_out.ready) begin
            r_ov <= r_sv || i_push;
            r_sv <= 1'b0;
        end else if (i_push) begin
            r_sv <= 1'b1;
        end
        if (!r_ov || o_out.ready) begin
            r_od <= r_sv ? r_sd : i_beat;
        end else if (i_push) begin
            r_sd <= i_beat;
        end
    end

    assign o_room      = !r_sv;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;
endmodule

// ----- sv/fixed_point_alu.sv -----
// fixed_point_alu: signed fixed-point alu top level
// depends on fpa_pkg, fpa_if, fpa_front, fpa_div_cell, fpa_out_buf
//
//  channel   dir  beat contents
//  i_in      in   action, operand_a, operand_b
//  o_out     out  result, a_greater, a_less, a_equal, overflow, divide_by_zero
//
// one beat per cycle sustained while the row is not stalled; the divider row
// holds one cell per quotient bit
// every action rides the same row, so beats leave in order
// the whole row stalls only when the skid register is full
// synchronous active-low reset clears valid bits only
module fixed_point_alu #(
    parameter int FRACTION_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);
    import fpa_pkg::*;

    localparam int NW = 33 + FRACTION_BITS;

    logic          en;
    logic          c_vld  [NW+1];
    t_side         c_side [NW+1];
    logic [NW-1:0] c_n    [NW+1];
    logic [NW-1:0] c_q    [NW+1];
    logic [33:0]   c_r    [NW+1];
    logic [33:0]   c_d    [NW+1];
    t_out_beat     fin;
    logic [NW-1:0] q;

    assign i_in.ready = en;

    fpa_front #(.FRACTION_BITS(FRACTION_BITS), .NW(NW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in.valid),
        .i_beat  (i_in.data),
        .o_vld   (c_vld[0]),
        .o_side  (c_side[0]),
        .o_n     (c_n[0]),
        .o_d     (c_d[0])
    );
    assign c_r[0] = '0;
    assign c_q[0] = '0;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        fpa_div_cell #(.NW(NW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[g]),
            .i_side  (c_side[g]),
            .i_n     (c_n[g]),
            .i_r     (c_r[g]),
            .i_d     (c_d[g]),
            .i_q     (c_q[g]),
            .o_vld   (c_vld[g+1]),
            .o_side  (c_side[g+1]),
            .o_n     (c_n[g+1]),
            .o_r     (c_r[g+1]),
            .o_d     (c_d[g+1]),
            .o_q     (c_q[g+1])
        );
    end

    // signed saturation of the quotient magnitude
    always_comb begin
        q   = c_q[NW];
        fin = c_side[NW].beat;
        if (c_side[NW].is_div) begin
            if (c_side[NW].q_neg) begin
                if (q > NW'(64'h8000_0000)) begin
                    fin.overflow = 1'b1;
                    fin.result   = W32_MIN;
                end else begin
                    fin.result = -$signed(q[31:0]);
                end
            end else begin
                if (q > NW'(64'h7fff_ffff)) begin
                    fin.overflow = 1'b1;
                    fin.result   = W32_MAX;
                end else begin
                    fin.result = q[31:0];
                end
            end
        end
    end

    fpa_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_vld[NW] && en),
        .i_beat  (fin),
        .o_room  (en),
        .o_out   (o_out)
    );
endmodule

// ----- sv/fpa_checker.sv -----
// fpa_props: port-level checks on the fixed-point alu result channel
// bound to fixed_point_alu; depends on fpa_pkg
module fpa_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input fpa_pkg::t_out_beat i_out_data
);
    import fpa_pkg::*;

    // exactly one compare outcome per beat
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot({i_out_data.a_greater, i_out_data.a_less,
                                 i_out_data.a_equal}))
        else $error("compare flags not one-hot");

    a_dbz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.divide_by_zero |-> !i_out_data.overflow)
        else $error("divide by zero with overflow");

    // b is zero, so a greater means positive a
    a_dbz_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.divide_by_zero && i_out_data.a_greater
        |-> i_out_data.result == W32_MAX)
        else $error("divide by zero of positive a not saturated high");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result beat changed");
endmodule

bind fixed_point_alu fpa_props u_fpa_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
